>>> rtl/bbe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbe_pkg;

  // Fixed field widths of the channels and the configuration port
  localparam int U_W        = 17;
  localparam int IDX_W      = 4;
  localparam int VAL_W      = 21;
  localparam int DEG_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  // Output value range (signed, 21 bits)
  localparam int VAL_MAX = 1048575;
  localparam int VAL_MIN = -1048576;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV  = 1'b1;

  // Register reset values
  localparam logic [DEG_W-1:0] DEGREE_RST = 4'd3;
  localparam logic             DERIV_RST  = 1'b0;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_MUL,
    ST_WRITE,
    ST_TAIL,
    ST_OREAD,
    ST_ODIFF,
    ST_OEMIT
  } bbe_state_t;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load_u;     // capture parameter, clear derivative history
    logic clr_saved;  // start of a recurrence level
    logic wr_en;      // work store write
    logic wr_one;     // write 1.0
    logic wr_tail;    // write carried term as top entry of a level
    logic rd_en;      // work store read
    logic mul_en;     // u * B[k]
    logic step_en;    // recurrence update of B[k] and carry
    logic diff_en;    // form output difference
    logic diff_use;   // current entry is inside the basis
    logic emit;       // load output register
    logic emit_last;  // final entry of this evaluation
    logic deriv;      // derivative mode of the item in progress
  } bbe_cmd_t;

endpackage

`default_nettype wire

>>> rtl/bbe_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Parameter channel
interface bbe_in_if import bbe_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [U_W-1:0] param_u;

  modport source (output valid, output param_u, input ready);
  modport sink   (input valid, input param_u, output ready);
endinterface

// Basis result channel
interface bbe_out_if import bbe_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        basis_index;
  logic signed [VAL_W-1:0] basis_value;
  logic                    last_entry;

  modport source (output valid, output basis_index, output basis_value,
                  output last_entry, input ready);
  modport sink   (input valid, input basis_index, input basis_value,
                  input last_entry, output ready);
endinterface

`default_nettype wire

>>> rtl/bbe_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle
module bbe_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/bbe_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: recurrence levels, inner steps and the output pass
module bbe_ctrl import bbe_pkg::*; #(
  parameter int MAX_DEGREE = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_ready,
  input  wire logic [DEG_W-1:0]              degree,
  input  wire logic                          deriv_mode,
  input  wire logic                          out_free,
  output      bbe_cmd_t                      cmd,
  output      logic [$clog2(MAX_DEGREE+1)-1:0] wr_addr,
  output      logic [$clog2(MAX_DEGREE+1)-1:0] rd_addr,
  output      logic [$clog2(MAX_DEGREE+1)-1:0] emit_idx,
  output      logic [$clog2(MAX_DEGREE+1)-1:0] n_deg
);

  localparam int AW = $clog2(MAX_DEGREE + 1);
  localparam int CW = (AW > DEG_W) ? AW : DEG_W;

  bbe_state_t    state_r, state_nxt;
  logic [AW-1:0] n_r, n_nxt;     // output degree
  logic [AW-1:0] m_r, m_nxt;     // build degree
  logic          mode_r, mode_nxt;
  logic [AW-1:0] j_r, j_nxt;     // recurrence level
  logic [AW-1:0] k_r, k_nxt;     // step within level
  logic [AW-1:0] i_r, i_nxt;     // output entry

  logic [CW-1:0] deg_ext;
  logic [AW-1:0] n_clamp;

  // Clamp the configured degree to MAX_DEGREE, the largest the store holds
  assign deg_ext = CW'(degree);
  assign n_clamp = (deg_ext > CW'(MAX_DEGREE)) ? AW'(MAX_DEGREE) : deg_ext[AW-1:0];

  assign emit_idx = i_r;
  assign n_deg    = n_r;

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      mode_r  <= mode_nxt;
    end
    n_r <= n_nxt;
    m_r <= m_nxt;
    j_r <= j_nxt;
    k_r <= k_nxt;
    i_r <= i_nxt;
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    m_nxt     = m_r;
    mode_nxt  = mode_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    in_ready  = 1'b0;
    wr_addr   = k_r;
    rd_addr   = k_r;
    cmd       = '0;
    cmd.deriv = mode_r;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_u = 1'b1;
          mode_nxt   = deriv_mode;
          n_nxt      = n_clamp;
          m_nxt      = deriv_mode ? (n_clamp - AW'(1)) : n_clamp;
          i_nxt      = '0;
          // derivative of degree zero needs no basis
          state_nxt  = (deriv_mode && (n_clamp == '0)) ? ST_OREAD : ST_INIT;
        end
      end

      ST_INIT: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_one    = 1'b1;
        cmd.clr_saved = 1'b1;
        wr_addr       = '0;
        if (m_r == '0) begin
          i_nxt     = '0;
          state_nxt = ST_OREAD;
        end else begin
          j_nxt     = AW'(1);
          k_nxt     = '0;
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        cmd.rd_en = 1'b1;
        rd_addr   = k_r;
        state_nxt = ST_MUL;
      end

      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_WRITE;
      end

      ST_WRITE: begin
        cmd.wr_en   = 1'b1;
        cmd.step_en = 1'b1;
        wr_addr     = k_r;
        if (k_r == (j_r - AW'(1))) begin
          state_nxt = ST_TAIL;
        end else begin
          // next read overlaps this write
          k_nxt     = k_r + AW'(1);
          cmd.rd_en = 1'b1;
          rd_addr   = k_r + AW'(1);
          state_nxt = ST_MUL;
        end
      end

      ST_TAIL: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_tail   = 1'b1;
        cmd.clr_saved = 1'b1;
        wr_addr       = j_r;
        if (j_r == m_r) begin
          i_nxt     = '0;
          state_nxt = ST_OREAD;
        end else begin
          j_nxt     = j_r + AW'(1);
          k_nxt     = '0;
          cmd.rd_en = 1'b1;
          rd_addr   = '0;
          state_nxt = ST_MUL;
        end
      end

      ST_OREAD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = i_r;
        state_nxt = ST_ODIFF;
      end

      ST_ODIFF: begin
        cmd.diff_en  = 1'b1;
        // entry n lies past the degree n-1 basis in derivative mode
        cmd.diff_use = !mode_r || (i_r != n_r);
        state_nxt    = ST_OEMIT;
      end

      ST_OEMIT: begin
        if (out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = (i_r == n_r);
          if (i_r == n_r) begin
            state_nxt = ST_IDLE;
          end else begin
            i_nxt     = i_r + AW'(1);
            cmd.rd_en = 1'b1;
            rd_addr   = i_r + AW'(1);
            state_nxt = ST_ODIFF;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/bbe_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

// Work store, shared multiplier, recurrence adder and output stage
module bbe_datapath import bbe_pkg::*; #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bbe_cmd_t                        cmd,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0] wr_addr,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0] rd_addr,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0] emit_idx,
  input  wire logic [$clog2(MAX_DEGREE+1)-1:0] n_deg,
  input  wire logic [U_W-1:0]                  in_param_u,
  output      logic                            out_free,
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic [IDX_W-1:0]                out_index,
  output      logic signed [VAL_W-1:0]         out_value,
  output      logic                            out_last
);

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = FRAC_BITS + 1;             // store word, 0..1.0
  localparam int PW2   = 2 * SW;                    // u * B product
  localparam int WW    = (U_W > SW) ? U_W : SW;     // parameter compare width
  localparam int DW    = SW + 1;                    // signed difference
  localparam int SCW   = AW + 1;                    // signed scale
  localparam int PW    = DW + SCW;                  // scaled difference
  localparam int EW    = (PW > VAL_W) ? PW : VAL_W; // saturation compare width
  localparam int IXW   = (AW > IDX_W) ? AW : IDX_W;

  localparam logic [SW-1:0]         ONE       = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [SCW-1:0] SCALE_ONE = SCW'(1);
  localparam logic signed [EW-1:0]  VMAX      = EW'(VAL_MAX);
  localparam logic signed [EW-1:0]  VMIN      = EW'(VAL_MIN);

  logic [SW-1:0]  u_r;
  logic [SW-1:0]  saved_r;
  logic [SW-1:0]  t_r;
  logic [PW2-1:0] prod_r;
  logic [SW-1:0]  prev_r;
  logic signed [DW-1:0] diff_r;

  logic [SW-1:0]  rd_data;
  logic [SW-1:0]  wr_data;
  logic [WW-1:0]  u_ext;
  logic [SW-1:0]  u_sat;
  logic [SW-1:0]  prod_hi;
  logic           round_up;
  logic [SW:0]    step_sum;
  logic [SW-1:0]  curr;
  logic signed [DW-1:0]  diff_nxt;
  logic signed [SCW-1:0] scale;
  logic signed [PW-1:0]  scaled;
  logic signed [EW-1:0]  scaled_ext;
  logic signed [VAL_W-1:0] val_sat;
  logic [IXW-1:0] idx_ext;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_index_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  // Work store
  bbe_ram #(
    .WIDTH (SW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Parameter above 1.0 saturates
  assign u_ext = WW'(in_param_u);
  assign u_sat = (u_ext > WW'(ONE)) ? ONE : u_ext[SW-1:0];

  // floor(u*t) and floor((1-u)*t) = t - ceil(u*t), both from one product
  assign prod_hi  = prod_r[FRAC_BITS +: SW];
  assign round_up = |prod_r[FRAC_BITS-1:0];
  assign step_sum = {1'b0, saved_r} + {1'b0, t_r} - {1'b0, prod_hi} - (SW+1)'(round_up);

  // Store write data
  always_comb begin
    priority if (cmd.wr_one) begin
      wr_data = ONE;
    end else if (cmd.wr_tail) begin
      wr_data = saved_r;
    end else begin
      wr_data = step_sum[SW-1:0];
    end
  end

  // Output difference: B[i-1] - B[i] in derivative mode, B[i] otherwise
  assign curr     = cmd.diff_use ? rd_data : '0;
  assign diff_nxt = cmd.deriv ? ($signed({1'b0, prev_r}) - $signed({1'b0, curr}))
                              : $signed({1'b0, curr});

  // Scale by n in derivative mode (by 1 otherwise) and saturate to the field range
  assign scale      = cmd.deriv ? $signed({1'b0, n_deg}) : SCALE_ONE;
  assign scaled     = PW'(diff_r) * PW'(scale);
  assign scaled_ext = EW'(scaled);

  always_comb begin
    priority if (scaled_ext > VMAX) begin
      val_sat = VMAX[VAL_W-1:0];
    end else if (scaled_ext < VMIN) begin
      val_sat = VMIN[VAL_W-1:0];
    end else begin
      val_sat = scaled_ext[VAL_W-1:0];
    end
  end

  assign idx_ext = IXW'(emit_idx);

  // Recurrence registers
  always_ff @(posedge clk) begin
    if (cmd.load_u) begin
      u_r    <= u_sat;
      prev_r <= '0;
    end else if (cmd.diff_en) begin
      prev_r <= curr;
    end
    if (cmd.mul_en) begin
      prod_r <= PW2'(u_r) * PW2'(rd_data);
      t_r    <= rd_data;
    end
    if (cmd.clr_saved) begin
      saved_r <= '0;
    end else if (cmd.step_en) begin
      saved_r <= prod_hi;
    end
    if (cmd.diff_en) begin
      diff_r <= diff_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.emit) begin
      out_index_r <= idx_ext[IDX_W-1:0];
      out_value_r <= val_sat;
      out_last_r  <= cmd.emit_last;
    end
  end

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_index = out_index_r;
  assign out_value = out_value_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

>>> rtl/bernstein_basis_eval.sv
`timescale 1ns / 1ps
`default_nettype none

// Bernstein basis evaluator. Each parameter u (unsigned Q1.16 by default,
// FRAC_BITS fraction bits; values above 1.0 taken as 1.0) yields degree+1
// results in index order: the basis values B(i,n)(u), or in derivative mode
// n*(B(i-1,n-1) - B(i,n-1)) with both ends zero; the last result carries
// last_entry. Products are floored to FRAC_BITS fraction bits; the degree is
// clamped to MAX_DEGREE. The basis is built by the triangular recurrence on
// one shared multiplier against a simple dual-port work store: each inner
// step runs a multiply state and then a write-back state, and each level ends
// with a tail write. The output pass waits while the result channel stalls.
// A new parameter is taken as soon as the final result sits in the output
// register.
// Configuration: cfg_index 0 is degree, 1 is derivative_mode; write only
// while idle.
module bernstein_basis_eval import bbe_pkg::*; #(
  parameter int MAX_DEGREE = 15,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  bbe_in_if.sink                     in_chan,
  bbe_out_if.source                  out_chan,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_DEGREE + 1);

  logic [DEG_W-1:0] degree_r;
  logic             deriv_r;

  bbe_cmd_t      cmd;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] emit_idx;
  logic [AW-1:0] n_deg;
  logic          out_free;
  logic          in_ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEGREE_RST;
      deriv_r  <= DERIV_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_DEGREE: degree_r <= cfg_wdata[DEG_W-1:0];
        CFG_DERIV:  deriv_r  <= cfg_wdata[0];
      endcase
    end
  end

  assign in_chan.ready = in_ready;

  bbe_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_ready),
    .degree     (degree_r),
    .deriv_mode (deriv_r),
    .out_free   (out_free),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .emit_idx   (emit_idx),
    .n_deg      (n_deg)
  );

  bbe_datapath #(
    .MAX_DEGREE (MAX_DEGREE),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .wr_addr    (wr_addr),
    .rd_addr    (rd_addr),
    .emit_idx   (emit_idx),
    .n_deg      (n_deg),
    .in_param_u (in_chan.param_u),
    .out_free   (out_free),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_index  (out_chan.basis_index),
    .out_value  (out_chan.basis_value),
    .out_last   (out_chan.last_entry)
  );

endmodule

`default_nettype wire

>>> rtl/bbe_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks of the evaluator
module bbe_checker import bbe_pkg::*; (
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [IDX_W-1:0]        out_index,
  input wire logic signed [VAL_W-1:0] out_value,
  input wire logic                    out_last
);

  logic [1:0]       pending_r;  // evaluations whose final result is still owed
  logic [IDX_W-1:0] exp_idx_r;  // index of the next result
  logic             in_xfer;
  logic             out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      exp_idx_r <= '0;
    end else begin
      pending_r <= pending_r + 2'(in_xfer) - 2'(out_xfer && out_last);
      if (out_xfer) begin
        exp_idx_r <= out_last ? '0 : (out_index + IDX_W'(1));
      end
    end
  end

  // A stalled result stays offered
  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_index) && $stable(out_value) &&
                                $stable(out_last))
    else $error("result payload changed while stalled");

  // No result without an evaluation in progress
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result with no evaluation outstanding");

  // Results come in index order, restarting at zero after the last one
  a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer |-> out_index == exp_idx_r)
    else $error("basis index out of sequence");

endmodule

bind bernstein_basis_eval bbe_checker u_bbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_index (out_chan.basis_index),
  .out_value (out_chan.basis_value),
  .out_last  (out_chan.last_entry)
);

`default_nettype wire
